// File: rtl/core/nps_pkg.sv
`default_nettype none
package nps_pkg;

    // Coordinate and arithmetic widths
    localparam int COORD_W  = 16;
    localparam int DIFF_W   = 17;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 68;
    localparam int ACC_W    = 36;
    localparam int LEN_W    = 33;
    localparam int RAD_W    = 50;
    localparam int ROOT_W   = 25;
    localparam int SQREM_W  = 28;
    localparam int INDEX_W  = 10;
    localparam int STEP_W   = 5;

    // Two quotient bits per divider step, two radicand bits per root step
    localparam logic [STEP_W-1:0] DIV_LAST  = 5'd24;
    localparam logic [STEP_W-1:0] SQRT_LAST = 5'd24;

    localparam logic [ROOT_W-1:0] DIST_MAX = {ROOT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_ACC,
        ST_DECIDE,
        ST_DIV,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_LEN_X,
        OP_LEN_Y,
        OP_DOTB_X,
        OP_DOTB_Y,
        OP_DOTA_X,
        OP_DOTA_Y,
        OP_END_X,
        OP_END_Y,
        OP_CRS_X,
        OP_CRS_Y,
        OP_CSQ
    } mul_op_t;

    typedef struct packed {
        logic    accept;
        logic    setup;
        logic    mul;
        logic    acc;
        mul_op_t op;
        logic    far;
        logic    div_step;
        logic    sqrt_load;
        logic    sqrt_step;
        logic    finish;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic measure;
        logic last;
        logic len_zero;
        logic dotb_pos;
        logic dota_pos;
        logic out_full;
    } status_t;

endpackage
`default_nettype wire

// File: rtl/core/nps_ctrl.sv
`default_nettype none
module nps_ctrl
    import nps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t            state_reg, state_next;
    mul_op_t           op_reg, op_next;
    logic              far_reg, far_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_LEN_X;
            far_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            far_reg   <= far_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Sequence one vertex through the datapath
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        far_next   = far_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.op     = op_reg;
        cmd.far    = far_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                op_next   = OP_LEN_X;
                if (status.measure)
                    state_next = ST_MUL;
                else
                    state_next = ST_FINISH;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_MUL;
                unique case (op_reg)
                    OP_LEN_X:  op_next = OP_LEN_Y;
                    OP_LEN_Y:  op_next = OP_DOTB_X;
                    OP_DOTB_X: op_next = OP_DOTB_Y;
                    OP_DOTB_Y: op_next = OP_DOTA_X;
                    OP_DOTA_X: op_next = OP_DOTA_Y;
                    OP_DOTA_Y: state_next = ST_DECIDE;
                    OP_END_X:  op_next = OP_END_Y;
                    OP_END_Y:
                    begin
                        cnt_next   = '0;
                        state_next = ST_SQRT;
                    end
                    OP_CRS_X:  op_next = OP_CRS_Y;
                    OP_CRS_Y:  op_next = OP_CSQ;
                    OP_CSQ:
                    begin
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_DECIDE:
            begin
                state_next = ST_MUL;
                if (status.len_zero)
                    state_next = ST_FINISH;
                else if (status.dotb_pos)
                begin
                    op_next  = OP_END_X;
                    far_next = 1'b1;
                end
                else if (status.dota_pos)
                begin
                    op_next  = OP_END_X;
                    far_next = 1'b0;
                end
                else
                    op_next = OP_CRS_X;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_SQRT_LOAD;
            end
            ST_SQRT_LOAD:
            begin
                cmd.sqrt_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                if (status.last)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!status.out_full || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/nps_datapath.sv
`default_nettype none
module nps_datapath
    import nps_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic signed [COORD_W-1:0]  query_x,
    input  wire logic signed [COORD_W-1:0]  query_y,
    input  wire logic signed [COORD_W-1:0]  vertex_x,
    input  wire logic signed [COORD_W-1:0]  vertex_y,
    input  wire logic                       first_vertex,
    input  wire logic                       last_vertex,
    input  wire cmd_t                       cmd,
    input  wire logic                       out_ready,
    output status_t                         status,
    output logic                            out_valid,
    output logic [INDEX_W-1:0]              insert_index,
    output logic [ROOT_W-1:0]               min_distance,
    output logic                            too_few_vertices
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_VERTICES);

    // Polyline tracking
    logic signed [COORD_W-1:0] qx_reg, qy_reg, px_reg, py_reg, cx_reg, cy_reg;
    logic [CW-1:0]             count_reg, best_idx_reg;
    logic [ROOT_W-1:0]         best_reg;
    logic                      start_reg, measure_reg, last_reg;

    // Arithmetic
    logic signed [DIFF_W-1:0]  abx_reg, aby_reg, apx_reg, apy_reg, bpx_reg, bpy_reg;
    logic signed [PROD_W-1:0]  p_reg;
    logic [LEN_W-1:0]          len_reg;
    logic signed [ACC_W-1:0]   accb_reg, acca_reg;
    logic [LEN_W-1:0]          drem_reg;
    logic [RAD_W-1:0]          dnum_reg, quo_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [SQREM_W-1:0]        srem_reg;
    logic [ROOT_W-1:0]         root_reg, dist_reg;

    // Output register
    logic                      out_valid_reg;
    logic [INDEX_W-1:0]        out_idx_reg;
    logic [ROOT_W-1:0]         out_dist_reg;
    logic                      out_few_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W-1:0]   p_acc, cross_abs;
    logic signed [DIFF_W-1:0]  ex, ey;
    logic [LEN_W:0]            dr1, dr2;
    logic [LEN_W-1:0]          dr1_k, dr2_k;
    logic                      dq1, dq2;
    logic [SQREM_W-1:0]        s_cand, s_trial;
    logic [RAD_W-1:0]          end_rad;

    assign p_acc     = p_reg[ACC_W-1:0];
    assign cross_abs = accb_reg[ACC_W-1] ? -accb_reg : accb_reg;
    assign ex        = cmd.far ? bpx_reg : apx_reg;
    assign ey        = cmd.far ? bpy_reg : apy_reg;
    assign end_rad   = {acca_reg[LEN_W:0] + p_acc[LEN_W:0], 16'h0000};

    // Pick multiplier operands
    always_comb
    begin
        mul_a = MUL_W'(abx_reg);
        mul_b = MUL_W'(abx_reg);
        case (cmd.op)
            OP_LEN_X:  begin mul_a = MUL_W'(abx_reg); mul_b = MUL_W'(abx_reg); end
            OP_LEN_Y:  begin mul_a = MUL_W'(aby_reg); mul_b = MUL_W'(aby_reg); end
            OP_DOTB_X: begin mul_a = MUL_W'(abx_reg); mul_b = MUL_W'(bpx_reg); end
            OP_DOTB_Y: begin mul_a = MUL_W'(aby_reg); mul_b = MUL_W'(bpy_reg); end
            OP_DOTA_X: begin mul_a = MUL_W'(abx_reg); mul_b = MUL_W'(apx_reg); end
            OP_DOTA_Y: begin mul_a = MUL_W'(aby_reg); mul_b = MUL_W'(apy_reg); end
            OP_END_X:  begin mul_a = MUL_W'(ex);      mul_b = MUL_W'(ex);      end
            OP_END_Y:  begin mul_a = MUL_W'(ey);      mul_b = MUL_W'(ey);      end
            OP_CRS_X:  begin mul_a = MUL_W'(abx_reg); mul_b = MUL_W'(apy_reg); end
            OP_CRS_Y:  begin mul_a = MUL_W'(aby_reg); mul_b = MUL_W'(apx_reg); end
            OP_CSQ:
            begin
                mul_a = cross_abs[MUL_W-1:0];
                mul_b = cross_abs[MUL_W-1:0];
            end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Two restoring division steps
    always_comb
    begin
        dr1   = {drem_reg, dnum_reg[RAD_W-1]};
        dq1   = dr1 >= {1'b0, len_reg};
        dr1_k = dq1 ? LEN_W'(dr1 - {1'b0, len_reg}) : dr1[LEN_W-1:0];
        dr2   = {dr1_k, dnum_reg[RAD_W-2]};
        dq2   = dr2 >= {1'b0, len_reg};
        dr2_k = dq2 ? LEN_W'(dr2 - {1'b0, len_reg}) : dr2[LEN_W-1:0];
    end

    // One square root digit
    always_comb
    begin
        s_cand  = {srem_reg[SQREM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
        s_trial = {1'b0, root_reg, 2'b01};
    end

    // Run the arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cx_reg   <= vertex_x;
            cy_reg   <= vertex_y;
        end
        if (cmd.setup)
        begin
            abx_reg  <= DIFF_W'(cx_reg) - DIFF_W'(px_reg);
            aby_reg  <= DIFF_W'(cy_reg) - DIFF_W'(py_reg);
            apx_reg  <= DIFF_W'(qx_reg) - DIFF_W'(px_reg);
            apy_reg  <= DIFF_W'(qy_reg) - DIFF_W'(py_reg);
            bpx_reg  <= DIFF_W'(qx_reg) - DIFF_W'(cx_reg);
            bpy_reg  <= DIFF_W'(qy_reg) - DIFF_W'(cy_reg);
            dist_reg <= DIST_MAX;
        end
        if (cmd.mul)
            p_reg <= mul_a * mul_b;
        if (cmd.acc)
        begin
            case (cmd.op)
                OP_LEN_X:  len_reg  <= p_reg[LEN_W-1:0];
                OP_LEN_Y:  len_reg  <= len_reg + p_reg[LEN_W-1:0];
                OP_DOTB_X: accb_reg <= p_acc;
                OP_DOTB_Y: accb_reg <= accb_reg + p_acc;
                OP_DOTA_X: acca_reg <= p_acc;
                OP_DOTA_Y: acca_reg <= acca_reg + p_acc;
                OP_END_X:  acca_reg <= p_acc;
                OP_END_Y:
                begin
                    rad_reg  <= end_rad;
                    srem_reg <= '0;
                    root_reg <= '0;
                end
                OP_CRS_X:  accb_reg <= p_acc;
                OP_CRS_Y:  accb_reg <= accb_reg - p_acc;
                OP_CSQ:
                begin
                    // Numerator is square << 16; quotient is known to fit the low bits
                    drem_reg <= p_reg[66:34];
                    dnum_reg <= {p_reg[33:0], 16'h0000};
                    quo_reg  <= '0;
                end
                default: ;
            endcase
        end
        if (cmd.div_step)
        begin
            drem_reg <= dr2_k;
            dnum_reg <= {dnum_reg[RAD_W-3:0], 2'b00};
            quo_reg  <= {quo_reg[RAD_W-3:0], dq1, dq2};
        end
        if (cmd.sqrt_load)
        begin
            rad_reg  <= quo_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (s_cand >= s_trial)
            begin
                srem_reg <= s_cand - s_trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                dist_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= s_cand;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                dist_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            if (count_reg < CW'(2))
            begin
                out_idx_reg  <= INDEX_W'(1);
                out_dist_reg <= DIST_MAX;
                out_few_reg  <= 1'b1;
            end
            else
            begin
                out_idx_reg  <= INDEX_W'(best_idx_reg);
                out_dist_reg <= best_reg;
                out_few_reg  <= 1'b0;
            end
        end
    end

    // Track the polyline and the best segment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg        <= '0;
            qy_reg        <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            count_reg     <= '0;
            best_idx_reg  <= CW'(1);
            best_reg      <= DIST_MAX;
            start_reg     <= 1'b0;
            measure_reg   <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (first_vertex)
                begin
                    qx_reg <= query_x;
                    qy_reg <= query_y;
                end
                start_reg   <= first_vertex || (count_reg == '0);
                measure_reg <= !first_vertex && (count_reg != '0)
                               && (count_reg < MAX_COUNT);
                last_reg    <= last_vertex;
            end
            if (cmd.finish)
            begin
                if (start_reg)
                begin
                    count_reg    <= CW'(1);
                    best_idx_reg <= CW'(1);
                    best_reg     <= DIST_MAX;
                end
                else if (measure_reg)
                begin
                    if (dist_reg < best_reg)
                    begin
                        best_reg     <= dist_reg;
                        best_idx_reg <= count_reg;
                    end
                    count_reg <= count_reg + 1'b1;
                end
                px_reg <= cx_reg;
                py_reg <= cy_reg;
            end
            if (cmd.emit)
            begin
                count_reg     <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.start    = start_reg;
        status.measure  = measure_reg;
        status.last     = last_reg;
        status.len_zero = (len_reg == '0);
        status.dotb_pos = !accb_reg[ACC_W-1] && (accb_reg != '0);
        status.dota_pos = acca_reg[ACC_W-1];
        status.out_full = out_valid_reg;
    end

    assign out_valid        = out_valid_reg;
    assign insert_index     = out_idx_reg;
    assign min_distance     = out_dist_reg;
    assign too_few_vertices = out_few_reg;

endmodule
`default_nettype wire

// File: rtl/core/nearest_polyline_segment.sv
`default_nettype none
// Nearest polyline segment finder. Send the vertices of a polyline one item
// at a time, with first_vertex on the first (the query point is latched then)
// and last_vertex on the final one; one result follows the last vertex with
// the insertion index (nearest segment plus one) and the point-to-segment
// distance in unsigned fixed point with 8 fraction bits. An item that starts
// a polyline or is not measured skips the arithmetic. A measured segment is
// worked through one shared 34x34 multiplier, one product at a time: six
// products, two more and a square root when an endpoint is nearest, and in
// the perpendicular case the cross product, its square, a radix-4 divider
// and a state that loads the root. The final vertex then passes a hand-over
// state, where it waits while an earlier result still waits. A result waits
// in an output register while the next vertex is taken.
module nearest_polyline_segment
    import nps_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] query_x,
    input  wire logic signed [COORD_W-1:0] query_y,
    input  wire logic signed [COORD_W-1:0] vertex_x,
    input  wire logic signed [COORD_W-1:0] vertex_y,
    input  wire logic                      first_vertex,
    input  wire logic                      last_vertex,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [INDEX_W-1:0]             insert_index,
    output logic [ROOT_W-1:0]              min_distance,
    output logic                           too_few_vertices
);

    cmd_t    cmd;
    status_t status;

    nps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nps_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .query_x          (query_x),
        .query_y          (query_y),
        .vertex_x         (vertex_x),
        .vertex_y         (vertex_y),
        .first_vertex     (first_vertex),
        .last_vertex      (last_vertex),
        .cmd              (cmd),
        .out_ready        (out_ready),
        .status           (status),
        .out_valid        (out_valid),
        .insert_index     (insert_index),
        .min_distance     (min_distance),
        .too_few_vertices (too_few_vertices)
    );

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import nps_pkg::*;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic               first;
        logic               last;
    } vertex_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [ROOT_W-1:0]  distance;
        logic               few;
    } nearest_t;

    localparam int VERTEX_LIMIT = 1024;
    localparam logic [ROOT_W-1:0] ALL_ONES = {ROOT_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] query_x = '0, query_y = '0, vertex_x = '0, vertex_y = '0;
    logic first_vertex = 1'b0, last_vertex = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [INDEX_W-1:0] insert_index;
    logic [ROOT_W-1:0] min_distance;
    logic too_few_vertices;

    nearest_polyline_segment dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .query_x(query_x), .query_y(query_y), .vertex_x(vertex_x),
        .vertex_y(vertex_y), .first_vertex(first_vertex),
        .last_vertex(last_vertex), .out_valid(out_valid),
        .out_ready(out_ready), .insert_index(insert_index),
        .min_distance(min_distance), .too_few_vertices(too_few_vertices)
    );

    always #10 clk = ~clk;

    vertex_item_t pending_items[$];
    nearest_t     expected_results[$];
    int  failures = 0;
    int  send_idle_pct = 0, recv_idle_pct = 0;
    int  hold_off_cycles = 0;
    bit  send_pause = 1'b0;
    bit  all_queued = 1'b0;
    int  quiet_cycles = 0;
    int  queued_items = 0;

    // predictor state
    logic [15:0] p_qx = '0, p_qy = '0, p_prevx = '0, p_prevy = '0;
    int unsigned p_count = 0;
    int unsigned p_best_index = 1;
    logic [ROOT_W-1:0] p_best_dist = ALL_ONES;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [ROOT_W-1:0] clamp_dist(longint unsigned d);
        return (d > 64'h1FFFFFF) ? ALL_ONES : d[ROOT_W-1:0];
    endfunction

    function automatic logic [ROOT_W-1:0] segment_distance(
        longint px, longint py, longint x1, longint y1, longint x2, longint y2);
        longint abx, aby, len2, dot_b, dot_a, cr, dx, dy;
        logic [127:0] num;
        logic [127:0] quo;
        abx = x2 - x1;
        aby = y2 - y1;
        len2 = abx * abx + aby * aby;
        dot_b = abx * (px - x2) + aby * (py - y2);
        dot_a = -abx * (px - x1) - aby * (py - y1);
        if (len2 == 0)
            return ALL_ONES;
        if (dot_b > 0)
        begin
            dx = px - x2; dy = py - y2;
            return clamp_dist(int_sqrt(longint'(dx * dx + dy * dy) << 16));
        end
        if (dot_a > 0)
        begin
            dx = px - x1; dy = py - y1;
            return clamp_dist(int_sqrt(longint'(dx * dx + dy * dy) << 16));
        end
        cr = abx * (py - y1) - aby * (px - x1);
        if (cr < 0) cr = -cr;
        num = (128'(cr) * 128'(cr)) << 16;
        quo = num / 128'(len2);
        return clamp_dist(int_sqrt(quo[63:0]));
    endfunction

    // advance the predictor by one accepted vertex
    task automatic predict_vertex(vertex_item_t it);
        logic [ROOT_W-1:0] d;
        nearest_t r;
        if (it.first)
        begin
            p_qx = it.qx;
            p_qy = it.qy;
        end
        if (it.first || p_count == 0)
        begin
            p_count = 1;
            p_best_index = 1;
            p_best_dist = ALL_ONES;
        end
        else if (p_count < VERTEX_LIMIT)
        begin
            d = segment_distance($signed(p_qx), $signed(p_qy), $signed(p_prevx),
                                 $signed(p_prevy), it.vx, it.vy);
            if (d < p_best_dist)
            begin
                p_best_dist = d;
                p_best_index = p_count;
            end
            p_count++;
        end
        p_prevx = it.vx;
        p_prevy = it.vy;
        if (it.last)
        begin
            if (p_count < 2)
                r = '{index: 1, distance: ALL_ONES, few: 1'b1};
            else
                r = '{index: p_best_index[INDEX_W-1:0], distance: p_best_dist,
                      few: 1'b0};
            expected_results.push_back(r);
            p_count = 0;
        end
    endtask

    // driver: offer pending items, hold payload until accepted
    always @(posedge clk)
    begin
        vertex_item_t it;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                it = pending_items.pop_front();
                predict_vertex(it);
            end
            if ((in_valid && !in_ready) ||
                (pending_items.size() != 0 && !send_pause &&
                 $urandom_range(99) >= send_idle_pct))
            begin
                if (!(in_valid && !in_ready))
                begin
                    it = pending_items[0];
                    query_x <= it.qx; query_y <= it.qy;
                    vertex_x <= it.vx; vertex_y <= it.vy;
                    first_vertex <= it.first; last_vertex <= it.last;
                end
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver ready, with optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        nearest_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result index=%0d distance=%0h few=%0b",
                         $time, insert_index, min_distance, too_few_vertices);
                failures++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (insert_index !== exp_r.index)
                begin
                    $display("%0t insert_index expected %0d actual %0d",
                             $time, exp_r.index, insert_index);
                    failures++;
                end
                if (min_distance !== exp_r.distance)
                begin
                    $display("%0t min_distance expected %0h actual %0h",
                             $time, exp_r.distance, min_distance);
                    failures++;
                end
                if (too_few_vertices !== exp_r.few)
                begin
                    $display("%0t too_few_vertices expected %0b actual %0b",
                             $time, exp_r.few, too_few_vertices);
                    failures++;
                end
            end
        end
    end

    // watchdog: count cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_coord(int span);
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 16'sh7FFF;
        if (pick == 1) return 16'sh8000;
        if (pick < 5) return 16'($urandom);
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic add_item(logic signed [15:0] qx, qy, vx, vy, logic f, l);
        vertex_item_t it;
        it = '{qx: qx, qy: qy, vx: vx, vy: vy, first: f, last: l};
        pending_items.push_back(it);
        queued_items++;
    endtask

    // queue one polyline of n vertices around a common region
    task automatic add_polyline(int n, int span, bit flagged);
        logic signed [15:0] qx, qy, vx, vy;
        qx = rand_coord(span);
        qy = rand_coord(span);
        for (int i = 0; i < n; i++)
        begin
            vx = rand_coord(span);
            vy = rand_coord(span);
            // repeat a vertex now and then for zero-length segments
            if (i > 0 && $urandom_range(15) == 0)
            begin
                vx = pending_items[$].vx;
                vy = pending_items[$].vy;
            end
            add_item(qx, qy, vx, vy, (i == 0) && flagged, i == n - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic run_random(int count);
        int n;
        int target;
        target = queued_items + count;
        while (queued_items < target)
        begin
            case ($urandom_range(19))
                0: add_item(rand_coord(100), rand_coord(100), rand_coord(100),
                            rand_coord(100), 1'($urandom), 1'($urandom));
                1: add_polyline(1, 100, 1'b1);
                2: add_polyline(2 + $urandom_range(3), 50, 1'b0);
                default:
                begin
                    n = 2 + $urandom_range(6);
                    add_polyline(n, ($urandom_range(1)) ? 200 : 32767, 1'b1);
                end
            endcase
            while (pending_items.size() > 40) @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: start without a flag, extremes, degenerate, too few
        add_item(16'sd5, 16'sd5, 16'sd0, 16'sd0, 1'b0, 1'b0);
        add_item(16'sd5, 16'sd5, 16'sd10, 16'sd0, 1'b0, 1'b1);
        add_item(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
        add_item(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1);
        add_item(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1, 1'b0);
        add_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1);
        add_item(16'sd3, 16'sd4, 16'sd1, 16'sd1, 1'b1, 1'b1);
        add_item(16'sd0, 16'sd0, 16'sd7, 16'sd7, 1'b1, 1'b0);
        add_item(16'sd0, 16'sd0, 16'sd7, 16'sd7, 1'b0, 1'b0);
        add_item(16'sd0, 16'sd0, 16'sd7, 16'sd7, 1'b0, 1'b1);
        // endpoint before, endpoint past, perpendicular, tie on two segments
        add_item(16'sd0, 16'sd0, -16'sd10, 16'sd5, 1'b1, 1'b0);
        add_item(16'sd0, 16'sd0, 16'sd10, 16'sd5, 1'b0, 1'b0);
        add_item(16'sd0, 16'sd0, 16'sd20, 16'sd5, 1'b0, 1'b0);
        add_item(16'sd0, 16'sd0, 16'sd30, 16'sd0, 1'b0, 1'b0);
        add_item(16'sd0, 16'sd0, 16'sd10, -16'sd5, 1'b0, 1'b0);
        add_item(16'sd0, 16'sd0, -16'sd10, -16'sd5, 1'b0, 1'b1);
        add_item(16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b1, 1'b0);
        add_item(16'sd9, 16'sd9, 16'sd3, 16'sd0, 1'b1, 1'b1);
        wait_drained();

        // overflow the vertex limit once
        for (int i = 0; i < VERTEX_LIMIT + 4; i++)
            add_item(16'sd0, 16'sd0, 16'(i), 16'($urandom_range(1)),
                     i == 0, i == VERTEX_LIMIT + 3);
        wait_drained();

        send_idle_pct = 27; recv_idle_pct = 69;
        run_random(110);
        hold_off_cycles = 600;
        run_random(90);
        wait_drained();
        // pause the sender until every expected result is back
        run_random(20);
        send_pause = 1'b1;
        while (expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (50) @(posedge clk);
        send_pause = 1'b0;
        wait_drained();
        send_idle_pct = 69; recv_idle_pct = 27;
        run_random(180);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(200);
        wait_drained();

        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
rtl/core/nps_pkg.sv
rtl/core/nps_ctrl.sv
rtl/core/nps_datapath.sv
rtl/core/nearest_polyline_segment.sv
verif/testbench.sv
